[design/tfg_pkg.sv]
package tfg_pkg;

   localparam int TABLE_ENTRIES_DEF = 121;
   localparam int AVG_DEPTH_DEF     = 11;
   localparam int TABLE_CAP         = 256;

   // register indexes
   localparam logic [1:0] REG_OVER = 2'd0;
   localparam logic [1:0] REG_ON   = 2'd1;
   localparam logic [1:0] REG_OFF  = 2'd2;
   localparam logic [1:0] REG_MIN  = 2'd3;

   localparam logic [1:0] ZONE_HOLD = 2'd0;
   localparam logic [1:0] ZONE_STOP = 2'd1;
   localparam logic [1:0] ZONE_REG  = 2'd2;
   localparam logic [1:0] ZONE_EMER = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VDIV,
      ST_SEARCH,
      ST_MAPDIV,
      ST_DECIDE,
      ST_SHIFT,
      ST_AVGDIV,
      ST_CLEAR,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic vdiv_start;
      logic search_step;
      logic map_start;
      logic decide;
      logic shift_step;
      logic avg_start;
      logic clear_step;
      logic present;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_busy;
      logic search_done;
      logic idx_last;
      logic zone_reg;
      logic zone_stop;
   } sts_type;

   typedef logic [TABLE_CAP-1:0][15:0] qtab_type;

   // table entries in units of 0.0001 V, zero past the given set
   function automatic logic [15:0] volt_e4(input logic [7:0] i);
      logic [15:0] r;
      case (i)
         8'd0: r = 16'd27427; 8'd1: r = 16'd27206; 8'd2: r = 16'd26981;
         8'd3: r = 16'd26751; 8'd4: r = 16'd26517; 8'd5: r = 16'd26278;
         8'd6: r = 16'd26035; 8'd7: r = 16'd25789; 8'd8: r = 16'd25538;
         8'd9: r = 16'd25283; 8'd10: r = 16'd25024; 8'd11: r = 16'd24762;
         8'd12: r = 16'd24496; 8'd13: r = 16'd24226; 8'd14: r = 16'd23954;
         8'd15: r = 16'd23678; 8'd16: r = 16'd23400; 8'd17: r = 16'd23118;
         8'd18: r = 16'd22835; 8'd19: r = 16'd22549; 8'd20: r = 16'd22261;
         8'd21: r = 16'd21971; 8'd22: r = 16'd21680; 8'd23: r = 16'd21387;
         8'd24: r = 16'd21092; 8'd25: r = 16'd20796; 8'd26: r = 16'd20498;
         8'd27: r = 16'd20200; 8'd28: r = 16'd19901; 8'd29: r = 16'd19601;
         8'd30: r = 16'd19300; 8'd31: r = 16'd19001; 8'd32: r = 16'd18701;
         8'd33: r = 16'd18402; 8'd34: r = 16'd18104; 8'd35: r = 16'd17806;
         8'd36: r = 16'd17510; 8'd37: r = 16'd17214; 8'd38: r = 16'd16920;
         8'd39: r = 16'd16628; 8'd40: r = 16'd16337; 8'd41: r = 16'd16047;
         8'd42: r = 16'd15758; 8'd43: r = 16'd15472; 8'd44: r = 16'd15188;
         8'd45: r = 16'd14906; 8'd46: r = 16'd14627; 8'd47: r = 16'd14350;
         8'd48: r = 16'd14076; 8'd49: r = 16'd13804; 8'd50: r = 16'd13536;
         8'd51: r = 16'd13271; 8'd52: r = 16'd13008; 8'd53: r = 16'd12749;
         8'd54: r = 16'd12493; 8'd55: r = 16'd12240; 8'd56: r = 16'd11991;
         8'd57: r = 16'd11745; 8'd58: r = 16'd11502; 8'd59: r = 16'd11263;
         8'd60: r = 16'd11028; 8'd61: r = 16'd10800; 8'd62: r = 16'd10575;
         8'd63: r = 16'd10354; 8'd64: r = 16'd10137; 8'd65: r = 16'd9923;
         8'd66: r = 16'd9714; 8'd67: r = 16'd9508; 8'd68: r = 16'd9305;
         8'd69: r = 16'd9107; 8'd70: r = 16'd8912; 8'd71: r = 16'd8719;
         8'd72: r = 16'd8531; 8'd73: r = 16'd8346; 8'd74: r = 16'd8165;
         8'd75: r = 16'd7987; 8'd76: r = 16'd7813; 8'd77: r = 16'd7642;
         8'd78: r = 16'd7475; 8'd79: r = 16'd7311; 8'd80: r = 16'd7150;
         8'd81: r = 16'd6994; 8'd82: r = 16'd6840; 8'd83: r = 16'd6690;
         8'd84: r = 16'd6543; 8'd85: r = 16'd6399; 8'd86: r = 16'd6259;
         8'd87: r = 16'd6121; 8'd88: r = 16'd5986; 8'd89: r = 16'd5855;
         8'd90: r = 16'd5726; 8'd91: r = 16'd5599; 8'd92: r = 16'd5475;
         8'd93: r = 16'd5354; 8'd94: r = 16'd5235; 8'd95: r = 16'd5119;
         8'd96: r = 16'd5006; 8'd97: r = 16'd4895; 8'd98: r = 16'd4787;
         8'd99: r = 16'd4681; 8'd100: r = 16'd4578; 8'd101: r = 16'd4478;
         8'd102: r = 16'd4380; 8'd103: r = 16'd4284; 8'd104: r = 16'd4191;
         8'd105: r = 16'd4100; 8'd106: r = 16'd4011; 8'd107: r = 16'd3924;
         8'd108: r = 16'd3839; 8'd109: r = 16'd3756; 8'd110: r = 16'd3674;
         8'd111: r = 16'd3595; 8'd112: r = 16'd3518; 8'd113: r = 16'd3442;
         8'd114: r = 16'd3368; 8'd115: r = 16'd3296; 8'd116: r = 16'd3225;
         8'd117: r = 16'd3157; 8'd118: r = 16'd3090; 8'd119: r = 16'd3024;
         8'd120: r = 16'd2960;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   // Q2.14 value of one entry, rounded
   function automatic logic [15:0] table_q14(input logic [7:0] i);
      logic [31:0] p;
      p = {16'd0, volt_e4(i)} * 32'd16384 + 32'd5000;
      return 16'(p / 32'd10000);
   endfunction

   // whole Q2.14 table, built once at elaboration
   function automatic qtab_type build_qtab();
      qtab_type r;
      for (int k = 0; k < TABLE_CAP; k++) r[k] = table_q14(8'(k));
      return r;
   endfunction

endpackage

[design/tfg_divider.sv]
// radix-2 restoring divider, one quotient bit per cycle
module tfg_divider #(
   parameter int W = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    trial;

   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, dsr_ff};

   // shift and subtract
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = (cnt_ff != '0) || start;
   assign quotient = quo_ff;
endmodule

[design/tfg_ctrl.sv]
module tfg_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  tfg_pkg::sts_type sts,
   output tfg_pkg::cmd_type cmd,
   output tfg_pkg::state_type state
);
   tfg_pkg::state_type state_ff, state_in;
   logic div_wait_ff, div_wait_in;

   // next state
   always_comb begin
      state_in    = state_ff;
      div_wait_in = 1'b0;
      unique case (state_ff)
         tfg_pkg::ST_IDLE:   if (req_tvalid) state_in = tfg_pkg::ST_VDIV;
         tfg_pkg::ST_VDIV: begin
            div_wait_in = 1'b1;
            if (div_wait_ff && !sts.div_busy) state_in = tfg_pkg::ST_SEARCH;
         end
         tfg_pkg::ST_SEARCH: if (sts.search_done) state_in = tfg_pkg::ST_MAPDIV;
         tfg_pkg::ST_MAPDIV: begin
            div_wait_in = 1'b1;
            if (div_wait_ff && !sts.div_busy) state_in = tfg_pkg::ST_DECIDE;
         end
         tfg_pkg::ST_DECIDE: begin
            if (sts.zone_reg)       state_in = tfg_pkg::ST_SHIFT;
            else if (sts.zone_stop) state_in = tfg_pkg::ST_CLEAR;
            else                    state_in = tfg_pkg::ST_OUT;
         end
         tfg_pkg::ST_SHIFT:  if (sts.idx_last) state_in = tfg_pkg::ST_AVGDIV;
         tfg_pkg::ST_AVGDIV: state_in = tfg_pkg::ST_OUT;
         tfg_pkg::ST_CLEAR:  if (sts.idx_last) state_in = tfg_pkg::ST_OUT;
         tfg_pkg::ST_OUT:    if (rsp_tready) state_in = tfg_pkg::ST_IDLE;
         default:            state_in = tfg_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         tfg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         tfg_pkg::ST_VDIV:   cmd.vdiv_start  = !div_wait_ff;
         tfg_pkg::ST_SEARCH: cmd.search_step = 1'b1;
         tfg_pkg::ST_MAPDIV: cmd.map_start   = !div_wait_ff;
         tfg_pkg::ST_DECIDE: cmd.decide      = 1'b1;
         tfg_pkg::ST_SHIFT:  cmd.shift_step  = 1'b1;
         tfg_pkg::ST_AVGDIV: cmd.avg_start   = 1'b1;
         tfg_pkg::ST_CLEAR:  cmd.clear_step  = 1'b1;
         tfg_pkg::ST_OUT: begin
            rsp_tvalid  = 1'b1;
            cmd.present = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tfg_pkg::ST_IDLE;
         div_wait_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         div_wait_ff <= div_wait_in;
      end
   end

   assign state = state_ff;
endmodule

[design/tfg_datapath.sv]
module tfg_datapath #(
   parameter int TABLE_ENTRIES = tfg_pkg::TABLE_ENTRIES_DEF,
   parameter int AVG_DEPTH     = tfg_pkg::AVG_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  tfg_pkg::cmd_type cmd,
   output tfg_pkg::sts_type sts,
   input  logic [11:0]      sensor_count,
   input  logic [11:0]      reference_count,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [6:0]       csr_wdata,
   output logic [6:0]       temperature_deg,
   output logic [6:0]       fan_duty,
   output logic             duty_changed,
   output logic             blackout,
   output logic [1:0]       zone
);
   localparam int N  = (TABLE_ENTRIES < 2) ? 2 :
                       ((TABLE_ENTRIES > tfg_pkg::TABLE_CAP) ? tfg_pkg::TABLE_CAP :
                        TABLE_ENTRIES);
   localparam int HW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SW = $clog2(AVG_DEPTH * 100 + 1);
   localparam int DW = 29;
   localparam logic [7:0] LAST = 8'(N - 1);
   localparam tfg_pkg::qtab_type QTAB = tfg_pkg::build_qtab();
   // ceil(2^24 / AVG_DEPTH), exact mean for any history sum
   localparam logic [24:0] RECIP = 25'(((1 << 24) + AVG_DEPTH - 1) / AVG_DEPTH);

   // configuration registers
   logic [6:0] over_ff, on_ff, off_ff, min_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         over_ff <= 7'd80;
         on_ff   <= 7'd40;
         off_ff  <= 7'd35;
         min_ff  <= 7'd20;
      end else if (csr_we) begin
         unique case (csr_index)
            tfg_pkg::REG_OVER: over_ff <= csr_wdata;
            tfg_pkg::REG_ON:   on_ff   <= csr_wdata;
            tfg_pkg::REG_OFF:  off_ff  <= csr_wdata;
            tfg_pkg::REG_MIN:  min_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared divider
   logic          div_start;
   logic [DW-1:0] div_a, div_b, div_q;
   logic          div_busy;

   tfg_divider #(.W(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .quotient (div_q)
   );

   logic [11:0] sen_ff, ref_ff;
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  temp_ff, temp_in;
   logic        done_ff, done_in;
   logic [6:0]  newd_ff, newd_in;
   logic        neg_ff;
   logic        empty_ff;
   logic [6:0]  hist_ff [AVG_DEPTH];
   logic [SW-1:0] sum_ff;
   logic [6:0]  duty_ff, old_ff;
   logic [1:0]  zone_ff;

   // mapping operands
   logic [13:0] hi_p;
   logic [6:0]  hi_v;
   logic signed [8:0] dt, dspan, dmin;
   logic signed [17:0] num;
   logic [17:0] num_mag;
   logic [8:0]  den_mag;

   assign hi_p    = 14'd68 * {7'd0, over_ff};
   assign hi_v    = 7'(({13'd0, hi_p} * 27'd5243) >> 19);  // /100, exact for 0..8636
   assign dt      = $signed({1'b0, temp_ff}) - $signed({2'b0, on_ff});
   assign dspan   = $signed({2'b0, hi_v}) - $signed({2'b0, on_ff});
   assign dmin    = 9'sd100 - $signed({2'b0, min_ff});
   assign num     = dt * dmin;
   assign num_mag = num[17] ? 18'(-num) : 18'(num);
   assign den_mag = dspan[8] ? 9'(-dspan) : 9'(dspan);

   always_comb begin
      div_start = cmd.vdiv_start || cmd.map_start;
      div_a     = {17'd0, sen_ff} * 29'd98304;
      div_b     = 29'd5 * {17'd0, ref_ff};
      if (cmd.map_start) begin
         div_a = {11'd0, num_mag};
         div_b = {20'd0, den_mag};
      end
   end

   // voltage and search; the divider holds the voltage quotient while searching
   logic [15:0] v_cur;
   logic [15:0] q_i, q_n, q_first, q_last;
   logic [16:0] diff2;
   logic [15:0] gap;
   assign v_cur   = (div_q > 29'd65535) ? 16'hFFFF : div_q[15:0];
   assign q_first = QTAB[0];
   assign q_last  = QTAB[LAST];
   assign q_i     = QTAB[idx_ff];
   assign q_n     = QTAB[idx_ff + 8'd1];
   assign diff2   = {q_i - v_cur, 1'b0};
   assign gap     = q_i - q_n;

   // mapped duty from quotient
   logic signed [18:0] mapped;
   always_comb begin
      mapped = (neg_ff ? -$signed({1'b0, div_q[17:0]}) : $signed({1'b0, div_q[17:0]}))
               + $signed({12'd0, min_ff});
   end

   // mean of the history by reciprocal multiply
   logic [SW+24:0] avg_p;
   assign avg_p = {25'd0, sum_ff} * {{SW{1'b0}}, RECIP};

   logic in_emer, in_reg, in_stop;
   assign in_emer = temp_ff >= {1'b0, over_ff};
   assign in_reg  = temp_ff >= {1'b0, on_ff};
   assign in_stop = (temp_ff <= {1'b0, off_ff}) && (duty_ff != 7'd0);

   always_comb begin
      idx_in  = idx_ff;
      temp_in = temp_ff;
      done_in = done_ff;
      newd_in = newd_ff;
      if (cmd.vdiv_start) begin
         idx_in  = 8'd0;
         done_in = 1'b0;
      end else if (cmd.search_step && !done_ff) begin
         if (ref_ff == 12'd0 || v_cur >= q_first) begin
            temp_in = 8'd0; done_in = 1'b1;
         end else if (v_cur <= q_last) begin
            temp_in = LAST; done_in = 1'b1;
         end else if ((idx_ff + 8'd1 < LAST) && (v_cur <= q_n)) begin
            idx_in = idx_ff + 8'd1;
         end else begin
            temp_in = (diff2 < {1'b0, gap}) ? idx_ff : idx_ff + 8'd1;
            done_in = 1'b1;
         end
      end
      if (cmd.decide) begin
         if (empty_ff || mapped > 19'sd100) newd_in = 7'd100;
         else if (mapped < 0)               newd_in = 7'd0;
         else                               newd_in = mapped[6:0];
      end
      if (cmd.decide || cmd.load) idx_in = 8'd0;
      else if (cmd.shift_step || cmd.clear_step)
         idx_in = sts.idx_last ? 8'd0 : idx_ff + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         duty_ff <= 7'd0;
         for (int k = 0; k < AVG_DEPTH; k++) hist_ff[k] <= 7'd0;
      end else begin
         done_ff <= done_in;
         if (cmd.decide) begin
            old_ff <= duty_ff;
            if (in_emer) begin
               duty_ff <= 7'd100; zone_ff <= tfg_pkg::ZONE_EMER;
            end else if (in_reg) begin
               zone_ff <= tfg_pkg::ZONE_REG;
            end else if (in_stop) begin
               duty_ff <= 7'd0; zone_ff <= tfg_pkg::ZONE_STOP;
            end else begin
               zone_ff <= tfg_pkg::ZONE_HOLD;
            end
         end
         if (cmd.shift_step) begin
            if (sts.idx_last) hist_ff[HW'(idx_ff)] <= newd_ff;
            else              hist_ff[HW'(idx_ff)] <= hist_ff[HW'(idx_ff + 8'd1)];
         end
         if (cmd.clear_step) hist_ff[HW'(idx_ff)] <= 7'd0;
         if (cmd.avg_start) duty_ff <= avg_p[30:24];
      end
      if (cmd.load) begin
         sen_ff <= sensor_count;
         ref_ff <= reference_count;
      end
      if (cmd.map_start) begin
         neg_ff   <= num[17] ^ dspan[8];
         empty_ff <= (dspan == 9'sd0);
      end
      // running sum of the shifted history
      if (cmd.decide) sum_ff <= '0;
      if (cmd.shift_step) begin
         if (sts.idx_last) sum_ff <= sum_ff + SW'(newd_ff);
         else              sum_ff <= sum_ff + SW'(hist_ff[HW'(idx_ff + 8'd1)]);
      end
      idx_ff  <= idx_in;
      temp_ff <= temp_in;
      newd_ff <= newd_in;
   end

   assign sts.div_busy    = div_busy;
   assign sts.search_done = done_ff;
   assign sts.idx_last    = (idx_ff == 8'(AVG_DEPTH - 1));
   assign sts.zone_reg    = in_reg && !in_emer;
   assign sts.zone_stop   = in_stop && !in_reg && !in_emer;

   assign temperature_deg = temp_ff[6:0];
   assign fan_duty        = duty_ff;
   assign duty_changed    = duty_ff != old_ff;
   assign blackout        = zone_ff == tfg_pkg::ZONE_EMER;
   assign zone            = zone_ff;
endmodule

[design/thermal_fan_guard_core.sv]
// Thermistor temperature guard: each accepted word (sensor and reference
// counts) is turned into a Q2.14 voltage by a 29-step shift/subtract
// divider, matched against the voltage table by a search that walks one
// entry per cycle, mapped to a duty by a second pass of the same divider,
// and, when regulating or stopping, the duty history is shifted or cleared;
// the mean comes from a reciprocal multiply. After the result is taken
// with rsp_tready high the block returns to idle before the next word is
// taken; one word is in flight at a time and the result stays on rsp until
// taken.
module thermal_fan_guard_core #(
   parameter int TABLE_ENTRIES = tfg_pkg::TABLE_ENTRIES_DEF,
   parameter int AVG_DEPTH     = tfg_pkg::AVG_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // sensor_count[11:0], reference_count[23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // temperature_deg[6:0], fan_duty[13:7],
                                    // duty_changed[14], blackout[15], zone[17:16]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   tfg_pkg::cmd_type   cmd;
   tfg_pkg::sts_type   sts;
   tfg_pkg::state_type state;
   logic [6:0] t, d;
   logic       ch, bo;
   logic [1:0] z;

   tfg_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd, .state
   );

   tfg_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .AVG_DEPTH(AVG_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .sensor_count    (req_tdata[11:0]),
      .reference_count (req_tdata[23:12]),
      .csr_we, .csr_index, .csr_wdata,
      .temperature_deg (t), .fan_duty (d), .duty_changed (ch),
      .blackout (bo), .zone (z)
   );

   assign rsp_tdata = {6'd0, z, bo, ch, d, t};

   // a word is taken only when nothing is in flight
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state == tfg_pkg::ST_IDLE)) else $error("busy accept");
   // result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result moved");
   // emergency always drives full duty
   a_emer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[13:7] == 7'd100)
      else $error("blackout without full duty");
endmodule
